// File: src/prwm_pkg.sv
`default_nettype none
package prwm_pkg;

   // event codes carried in req_tdata
   localparam logic [1:0] KIND_PULSE = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // unit_mode codes; any other code is treated as MODE_MSVY
   localparam logic [1:0] MODE_CPM  = 2'd0;
   localparam logic [1:0] MODE_USVH = 2'd1;
   localparam logic [1:0] MODE_MSVY = 2'd2;

   localparam int KIND_W    = 2;
   localparam int MODE_W    = 2;
   localparam int PER_SEC_W = 16;
   localparam int PER_MIN_W = 22;
   localparam int PEAK_W    = 16;
   localparam int DOSE_W    = 25;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 80;

   // Q16 dose factors: 0.81 and 7.0956 hundredths per cpm
   localparam int             K_W       = 19;
   localparam logic [K_W-1:0] USVH_Q16  = 19'd53084;
   localparam logic [K_W-1:0] MSVY_Q16  = 19'd465017;
   localparam int             FRAC_BITS = 16;
   localparam int             PROD_W    = PER_MIN_W + K_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_MULT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic tally_inc;
      logic clear_all;
      logic push;
      logic rd_issue;
      logic rd_in_win;
      logic mult;
      logic load_tick;
      logic load_clear;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: src/prwm_ram.sv
`default_nettype none
module prwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/prwm_ctrl.sv
`default_nettype none
module prwm_ctrl #(
   parameter int HISTORY_DEPTH = 64,
   parameter int WINDOW_LENGTH = 60
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic [prwm_pkg::KIND_W-1:0]   req_kind,
   output logic                               req_tready,
   input  wire prwm_pkg::status_type          sts,
   output prwm_pkg::cmd_type                  cmd
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int WIN   = (WINDOW_LENGTH < HISTORY_DEPTH) ? WINDOW_LENGTH : HISTORY_DEPTH;

   prwm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                clr_ff, clr_in;
   logic                accept;
   logic                cnt_last;

   assign accept   = req_tvalid && req_tready;
   assign cnt_last = (cnt_ff == IDX_W'(HISTORY_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prwm_pkg::S_IDLE;
         cnt_ff   <= '0;
         clr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         prwm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_kind)
                  prwm_pkg::KIND_PULSE: begin
                     cmd.tally_inc = 1'b1;
                  end
                  prwm_pkg::KIND_TICK: begin
                     cmd.push = 1'b1;
                     cnt_in   = '0;
                     clr_in   = 1'b0;
                     state_in = prwm_pkg::S_SCAN;
                  end
                  prwm_pkg::KIND_CLEAR: begin
                     cmd.clear_all = 1'b1;
                     clr_in        = 1'b1;
                     state_in      = prwm_pkg::S_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         prwm_pkg::S_SCAN: begin
            // entry cnt back from the newest one
            cmd.rd_issue  = 1'b1;
            cmd.rd_in_win = ({1'b0, cnt_ff} < (IDX_W + 1)'(WIN));
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = prwm_pkg::S_DRAIN;
            end
         end
         prwm_pkg::S_DRAIN: begin
            state_in = prwm_pkg::S_MULT;
         end
         prwm_pkg::S_MULT: begin
            cmd.mult = 1'b1;
            state_in = prwm_pkg::S_OUT;
         end
         prwm_pkg::S_OUT: begin
            if (sts.out_free) begin
               cmd.load_tick  = !clr_ff;
               cmd.load_clear = clr_ff;
               state_in       = prwm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = prwm_pkg::S_IDLE;
         end
      endcase
   end

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_tick || cmd.load_clear) |-> sts.out_free)
      else $error("result loaded while output slot busy");

   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == prwm_pkg::KIND_TICK) |=> state_ff == prwm_pkg::S_SCAN)
      else $error("tick did not start history scan");

   a_scan_full_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_issue && cnt_last) |=> (state_ff == prwm_pkg::S_DRAIN && cnt_ff == '0))
      else $error("history scan did not end after the last entry");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_tick && cmd.load_clear))
      else $error("tick and clear result loaded together");

endmodule
`default_nettype wire

// File: src/prwm_dpath.sv
`default_nettype none
module prwm_dpath #(
   parameter int HISTORY_DEPTH = 64,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire prwm_pkg::cmd_type               cmd,
   output prwm_pkg::status_type                 sts,
   input  wire logic                            csr_wr_en,
   input  wire logic [prwm_pkg::MODE_W-1:0]     csr_wr_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [prwm_pkg::PER_SEC_W-1:0]       per_second,
   output logic [prwm_pkg::PER_MIN_W-1:0]       per_minute,
   output logic [prwm_pkg::PEAK_W-1:0]          peak_second,
   output logic [prwm_pkg::DOSE_W-1:0]          dose_value
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   logic [prwm_pkg::MODE_W-1:0]    mode_ff;
   logic [COUNT_BITS-1:0]          tally_ff;
   logic [COUNT_BITS-1:0]          sec_ff;
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [IDX_W-1:0]               rd_ptr_ff;
   logic [HISTORY_DEPTH-1:0]       valid_ff;
   logic                           rd_act_ff, rd_vld_ff, rd_win_ff;
   logic [COUNT_BITS-1:0]          rd_data;
   logic [COUNT_BITS-1:0]          entry;
   logic [prwm_pkg::PER_MIN_W-1:0] sum_ff;
   logic [COUNT_BITS-1:0]          peak_ff;
   logic [prwm_pkg::K_W-1:0]       k_sel;
   logic [prwm_pkg::PROD_W-1:0]    prod_ff;
   logic                           out_vld_ff;
   logic [prwm_pkg::PER_SEC_W-1:0] o_sec_ff;
   logic [prwm_pkg::PER_MIN_W-1:0] o_min_ff;
   logic [prwm_pkg::PEAK_W-1:0]    o_peak_ff;
   logic [prwm_pkg::DOSE_W-1:0]    o_dose_ff;
   logic [prwm_pkg::DOSE_W-1:0]    dose_in;

   assign head_in = (head_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   prwm_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (head_in),
      .wr_data (tally_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // never-written slots read as zero
   assign entry = rd_vld_ff ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= prwm_pkg::MODE_CPM;
         tally_ff  <= '0;
         head_ff   <= '0;
         valid_ff  <= '0;
         rd_act_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         rd_act_ff <= cmd.rd_issue;
         if (cmd.clear_all) begin
            tally_ff <= '0;
            valid_ff <= '0;
         end else if (cmd.push) begin
            tally_ff          <= '0;
            head_ff           <= head_in;
            valid_ff[head_in] <= 1'b1;
         end else if (cmd.tally_inc && tally_ff != '1) begin
            tally_ff <= tally_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         sec_ff    <= tally_ff;
         rd_ptr_ff <= head_in;
         sum_ff    <= '0;
         peak_ff   <= '0;
      end else if (cmd.rd_issue) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? IDX_W'(HISTORY_DEPTH - 1) : rd_ptr_ff - 1'b1;
      end
      if (cmd.rd_issue) begin
         rd_vld_ff <= valid_ff[rd_ptr_ff];
         rd_win_ff <= cmd.rd_in_win;
      end
      if (rd_act_ff) begin
         if (rd_win_ff) begin
            sum_ff <= sum_ff + prwm_pkg::PER_MIN_W'(entry);
         end
         if (entry > peak_ff) begin
            peak_ff <= entry;
         end
      end
      if (cmd.mult) begin
         prod_ff <= prwm_pkg::PROD_W'(sum_ff) * prwm_pkg::PROD_W'(k_sel);
      end
   end

   assign k_sel = (mode_ff == prwm_pkg::MODE_USVH) ? prwm_pkg::USVH_Q16 : prwm_pkg::MSVY_Q16;

   assign dose_in = (mode_ff == prwm_pkg::MODE_CPM) ? prwm_pkg::DOSE_W'(sum_ff)
                  : prod_ff[prwm_pkg::FRAC_BITS +: prwm_pkg::DOSE_W];

   assign sts.out_free = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.load_tick || cmd.load_clear) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         o_sec_ff  <= prwm_pkg::PER_SEC_W'(sec_ff);
         o_min_ff  <= sum_ff;
         o_peak_ff <= prwm_pkg::PEAK_W'(peak_ff);
         o_dose_ff <= dose_in;
      end else if (cmd.load_clear) begin
         o_sec_ff  <= '0;
         o_min_ff  <= '0;
         o_peak_ff <= '0;
         o_dose_ff <= '0;
      end
   end

   assign rsp_tvalid  = out_vld_ff;
   assign per_second  = o_sec_ff;
   assign per_minute  = o_min_ff;
   assign peak_second = o_peak_ff;
   assign dose_value  = o_dose_ff;

   a_push_marks_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> valid_ff[head_ff])
      else $error("pushed history slot not marked valid");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> (valid_ff == '0 && tally_ff == '0))
      else $error("clear left history or tally");

   a_tally_zero_after_push: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> tally_ff == '0)
      else $error("tally not cleared by tick");

endmodule
`default_nettype wire

// File: src/pulse_rate_window_monitor_top.sv
// Channel | Dir | Ports             | Content
// req     | in  | req_t*            | tdata[1:0] event_kind
// rsp     | out | rsp_t*            | tdata: per_second, per_minute, peak_second, dose_value
// csr     | in  | csr_wr_en/_data   | unit_mode, no read-back
//
// A pulse only bumps the tally. A tick walks through these steps in order:
// one history RAM read per entry to form the window sum and the peak, a drain
// state for the RAM read, one multiply and one output load. A clear goes straight to the load.
// Synchronous reset zeroes tally, history valid bits and unit_mode at once.
// A result waits in the output register; the next transaction is accepted meanwhile.
`default_nettype none
module pulse_rate_window_monitor_top #(
   parameter int HISTORY_DEPTH = 64,
   parameter int WINDOW_LENGTH = 60,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [1:0] event_kind, [7:2] zero
   input  wire logic [prwm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] per_second, [37:16] per_minute, [53:38] peak_second,
   // [78:54] dose_value, [79] zero
   output logic [prwm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [prwm_pkg::MODE_W-1:0]         csr_wr_data
);

   prwm_pkg::cmd_type              cmd;
   prwm_pkg::status_type           sts;
   logic [prwm_pkg::PER_SEC_W-1:0] per_second;
   logic [prwm_pkg::PER_MIN_W-1:0] per_minute;
   logic [prwm_pkg::PEAK_W-1:0]    peak_second;
   logic [prwm_pkg::DOSE_W-1:0]    dose_value;

   prwm_ctrl #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tdata[prwm_pkg::KIND_W-1:0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   prwm_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .per_second  (per_second),
      .per_minute  (per_minute),
      .peak_second (peak_second),
      .dose_value  (dose_value)
   );

   assign rsp_tdata = {1'b0, dose_value, peak_second, per_minute, per_second};

endmodule
`default_nettype wire

// File: bench/prwm_rate_checker.sv
module prwm_rate_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [prwm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [prwm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_wr_en,
   input  wire logic [prwm_pkg::MODE_W-1:0]     csr_wr_data,
   output int                                   mismatch_count,
   output int                                   pending_count
);

   localparam int HIST_DEPTH = 64;
   localparam int WINDOW_LEN = 60;
   localparam int TALLY_W    = 16;

   // Q16 dose factors: 0.81 and 7.0956 hundredths per cpm
   localparam logic [18:0] USVH_FACTOR = 19'd53084;
   localparam logic [18:0] MSVY_FACTOR = 19'd465017;

   // laid out as rsp_tdata, top bit first
   typedef struct packed {
      logic                           pad;
      logic [prwm_pkg::DOSE_W-1:0]    dose_value;
      logic [prwm_pkg::PEAK_W-1:0]    peak_second;
      logic [prwm_pkg::PER_MIN_W-1:0] per_minute;
      logic [prwm_pkg::PER_SEC_W-1:0] per_second;
   } rate_report_type;

   logic [prwm_pkg::MODE_W-1:0] unit_mode;
   logic [TALLY_W-1:0]          tally;
   logic [TALLY_W-1:0]          history [HIST_DEPTH];
   rate_report_type             report_q [$];
   int                          mismatches = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [prwm_pkg::DOSE_W-1:0] scale_dose(
      input logic [prwm_pkg::PER_MIN_W-1:0] cpm,
      input logic [prwm_pkg::MODE_W-1:0]    mode);
      logic [prwm_pkg::PER_MIN_W+18:0] product;
      case (mode)
         prwm_pkg::MODE_CPM:  product = {cpm, 16'b0};
         prwm_pkg::MODE_USVH: product = cpm * USVH_FACTOR;
         default:             product = cpm * MSVY_FACTOR;  // unused mode acts as mSv/y
      endcase
      return product[prwm_pkg::FRAC_BITS +: prwm_pkg::DOSE_W];
   endfunction

   task automatic apply_event(input logic [prwm_pkg::KIND_W-1:0] kind);
      rate_report_type    r;
      logic [31:0]        sum;
      logic [TALLY_W-1:0] peak;
      case (kind)
         prwm_pkg::KIND_PULSE: begin
            if (tally != '1) tally = tally + 1'b1;
         end
         prwm_pkg::KIND_CLEAR: begin
            tally = '0;
            foreach (history[i]) history[i] = '0;
            report_q.push_back('0);
         end
         prwm_pkg::KIND_TICK: begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = tally;
            sum  = 0;
            peak = '0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
               if (i < WINDOW_LEN) sum = sum + history[i];
               if (history[i] > peak) peak = history[i];
            end
            r             = '0;
            r.per_second  = tally;
            r.per_minute  = sum[prwm_pkg::PER_MIN_W-1:0];
            r.peak_second = peak;
            r.dose_value  = scale_dose(sum[prwm_pkg::PER_MIN_W-1:0], unit_mode);
            tally         = '0;
            report_q.push_back(r);
         end
         default: ;  // unused opcode, no result
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic compare_report(input rate_report_type got);
      rate_report_type want;
      if (report_q.size() == 0) begin
         mismatches++;
         $display("%0t: result transaction with nothing expected, expected none, actual %h",
                  $time, got);
         return;
      end
      want = report_q.pop_front();
      check_field("per_second", 32'(want.per_second), 32'(got.per_second));
      check_field("per_minute", 32'(want.per_minute), 32'(got.per_minute));
      check_field("peak_second", 32'(want.peak_second), 32'(got.peak_second));
      check_field("dose_value", 32'(want.dose_value), 32'(got.dose_value));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unit_mode = prwm_pkg::MODE_CPM;
         tally     = '0;
         foreach (history[i]) history[i] = '0;
         report_q.delete();
      end else begin
         if (csr_wr_en) unit_mode = csr_wr_data;
         if (rsp_tvalid && rsp_tready) compare_report(rate_report_type'(rsp_tdata));
         if (req_tvalid && req_tready) apply_event(req_tdata[prwm_pkg::KIND_W-1:0]);
      end
      pending_count  <= report_q.size();
      mismatch_count <= mismatches;
   end

endmodule

// File: bench/pulse_rate_window_monitor_top_tb.sv
module pulse_rate_window_monitor_top_tb;

   localparam logic [prwm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [prwm_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 3000;
   localparam int PHASE_ITEMS  = 350;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [prwm_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [prwm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_wr_en;
   logic [prwm_pkg::MODE_W-1:0]     csr_wr_data;
   int                              mismatch_count;
   int                              pending_count;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_request  = 0;
   bit hold_done     = 0;
   int items_sent    = 0;

   pulse_rate_window_monitor_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   prwm_rate_checker u_rate_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("pulse_rate_window_monitor_top verification failed");
      $finish;
   end

   // receiver; one long hold-off on request, counted here
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_event(input logic [prwm_pkg::KIND_W-1:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(prwm_pkg::REQ_DATA_W-prwm_pkg::KIND_W){1'b0}}, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // wait out every pending result plus the tick latency, then optionally write unit_mode
   task automatic settle(input bit do_write, input logic [prwm_pkg::MODE_W-1:0] mode);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (do_write) begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= mode;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
      end
   endtask

   task automatic send_pulses_then_tick(input int pulses);
      repeat (pulses) send_event(prwm_pkg::KIND_PULSE);
      send_event(prwm_pkg::KIND_TICK);
   endtask

   // one second of pulses closed by a tick, sometimes broken by a clear or noise
   task automatic send_random_second();
      int pulses;
      int pick;
      pulses = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
      repeat (pulses) begin
         if ($urandom_range(199) == 0) send_event(KIND_UNUSED);
         send_event(prwm_pkg::KIND_PULSE);
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_event(prwm_pkg::KIND_CLEAR);
      end else if (pick < 6) begin
         send_event(KIND_UNUSED);
         send_event(prwm_pkg::KIND_TICK);
      end else begin
         send_event(prwm_pkg::KIND_TICK);
      end
   endtask

   task automatic random_phase();
      int goal;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_random_second();
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty history, small counts, ignored opcode, clear mid-second
      send_event(prwm_pkg::KIND_TICK);
      send_pulses_then_tick(3);
      send_event(KIND_UNUSED);
      send_event(prwm_pkg::KIND_PULSE);
      send_event(prwm_pkg::KIND_CLEAR);
      send_event(prwm_pkg::KIND_TICK);
      send_pulses_then_tick(2);
      settle(1, prwm_pkg::MODE_USVH);
      send_pulses_then_tick(5);
      settle(1, MODE_SPARE);
      send_pulses_then_tick(4);

      // no idling, with a long receiver hold-off up front
      settle(1, prwm_pkg::MODE_CPM);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1;
      random_phase();

      settle(1, prwm_pkg::MODE_USVH);
      send_idle_pct = 87;
      rsp_stall_pct = 0;
      random_phase();

      settle(1, prwm_pkg::MODE_MSVY);
      send_idle_pct = 0;
      rsp_stall_pct = 87;
      random_phase();

      settle(1, MODE_SPARE);
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      random_phase();

      // a busy second, then let it age out of the window and then the history
      settle(1, prwm_pkg::MODE_MSVY);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_pulses_then_tick(300);
      repeat (65) send_event(prwm_pkg::KIND_TICK);

      settle(0, prwm_pkg::MODE_CPM);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("pulse_rate_window_monitor_top verification clean");
      end else begin
         $display("pulse_rate_window_monitor_top verification failed");
      end
      $finish;
   end

endmodule
